### hw/rtl/tsmt_pkg.sv
// package for the threshold sweep minimum tree
// field widths, action codes, the empty mark, the count limit, states and compare unit result
// no dependencies
package tsmt_pkg;

    // field widths of the input and result words
    localparam int POS_W = 10;
    localparam int RB_W  = 11;
    localparam int VAL_W = 31;
    localparam int CNT_W = 11;

    // action codes of the input word
    localparam logic ACT_SET   = 1'b0;
    localparam logic ACT_SWEEP = 1'b1;

    // slot value type and the empty mark
    typedef logic [VAL_W-1:0] t_val;
    localparam t_val EMPTY_MARK = 31'h7FFF_FFFF;

    // highest count that the result can carry
    localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_CHECK_WAIT,
        ST_DESCEND,
        ST_LEAF,
        ST_UP,
        ST_CLIMB,
        ST_RESULT
    } t_state;

    // result of the shared compare unit
    typedef struct packed {
        logic a_le;
        t_val mn;
    } t_cmp_res;

endpackage

### hw/rtl/threshold_sweep_min_tree.sv
// top level of the threshold sweep minimum tree: sequencer, node memory and compare unit
// depends on tsmt_pkg, tsmt_mem and tsmt_cmp
//
// After reset the block clears all 2*P nodes of its node memory, one node a cycle
// (P = SIZE rounded up to a power of two); in_ready stays low meanwhile. It then works on
// one word at a time. A set writes the leaf and walks the path to the root, one level a
// cycle through the single write port, or goes straight to the result when the slot is out
// of range. A sweep searches for the next matching slot by stepping right and up the tree
// one level a cycle, reading a node through the check and check-wait states, and stepping
// down one level a cycle once a subtree holds a match; each slot it empties costs one such
// search plus a path update. The tree walks through the one memory and the one compare
// unit set the rate. Each result waits in the result state until taken.
module threshold_sweep_min_tree
    import tsmt_pkg::*;
#(
    parameter int SIZE = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input words
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_action,
    input  logic [POS_W-1:0] i_position,
    input  logic [RB_W-1:0]  i_right_bound,
    input  logic [VAL_W-1:0] i_value,
    // result words
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [CNT_W-1:0] o_removed_count
);

    localparam int LG = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int AW = LG + 1;
    localparam int BW = (LG + 1 > RB_W) ? LG + 1 : RB_W;
    localparam logic [BW-1:0] SIZE_B  = BW'(SIZE);
    localparam logic [BW-1:0] LEAF_B  = BW'(1) << LG;
    localparam logic [AW-1:0] ROOT    = AW'(1);
    localparam logic [AW-1:0] LAST_A  = '1;
    localparam logic [BW-1:0] ONE_B   = BW'(1);

    t_state          r_state, n_state;
    logic            r_act, n_act;
    t_val            r_thr, n_thr;
    logic [BW-1:0]   r_rbc, n_rbc;
    logic [AW-1:0]   r_node, n_node;
    logic [BW-1:0]   r_lo, n_lo;
    logic [BW-1:0]   r_span, n_span;
    logic [AW-1:0]   r_wnode, n_wnode;
    t_val            r_val, n_val;
    logic [CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]   r_clr, n_clr;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_val            mem_wdata;
    logic [AW-1:0]   rd_addr_a;
    t_val            rd_data_a;
    t_cmp_res        cmp_res;

    logic            in_acc;
    logic [BW-1:0]   pos_b;
    logic [BW-1:0]   rb_b;
    logic [BW-1:0]   half;
    logic [AW-1:0]   child;
    logic [BW-1:0]   child_lo;
    logic [AW-1:0]   parent;
    logic [CNT_W-1:0] count_inc;

    // node memory
    tsmt_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (rd_addr_a),
        .o_rdata_a (rd_data_a)
    );

    // shared compare unit
    tsmt_cmp u_cmp (
        .i_node (rd_data_a),
        .i_thr  (r_thr),
        .i_val  (r_val),
        .o_res  (cmp_res)
    );

    // handshake outputs
    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = (r_state == ST_RESULT);
    assign o_removed_count = r_count;
    assign in_acc          = i_in_valid && o_in_ready;

    // operand widening and walk helpers
    assign pos_b     = BW'(i_position);
    assign rb_b      = BW'(i_right_bound);
    assign half      = r_span >> 1;
    assign parent    = r_wnode >> 1;
    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + CNT_W'(1);

    // child chosen on the way down: left when it holds a match
    always_comb begin
        if (cmp_res.a_le) begin
            child    = r_node << 1;
            child_lo = r_lo;
        end else begin
            child    = (r_node << 1) | ROOT;
            child_lo = r_lo + half;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_act   <= ACT_SET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_act   <= n_act;
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        r_thr   <= n_thr;
        r_rbc   <= n_rbc;
        r_node  <= n_node;
        r_lo    <= n_lo;
        r_span  <= n_span;
        r_wnode <= n_wnode;
        r_val   <= n_val;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_thr     = r_thr;
        n_rbc     = r_rbc;
        n_node    = r_node;
        n_lo      = r_lo;
        n_span    = r_span;
        n_wnode   = r_wnode;
        n_val     = r_val;
        n_count   = r_count;
        n_clr     = r_clr;
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = r_val;
        rd_addr_a = r_node;

        case (r_state)
            // fill every node with the empty mark
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = EMPTY_MARK;
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST_A) begin
                    n_state = ST_IDLE;
                end
            end

            // take a word
            ST_IDLE: begin
                if (in_acc) begin
                    n_act   = i_action;
                    n_thr   = (i_value == EMPTY_MARK) ? EMPTY_MARK - VAL_W'(1) : i_value;
                    n_rbc   = (rb_b > SIZE_B) ? SIZE_B : rb_b;
                    n_node  = AW'(LEAF_B + pos_b);
                    n_lo    = pos_b;
                    n_span  = ONE_B;
                    n_val   = i_value;
                    n_count = '0;
                    n_state = ST_START;
                end
            end

            // set goes on to write its leaf, or to the result when out of range; sweep starts searching
            ST_START: begin
                if (r_act == ACT_SWEEP) begin
                    n_state = ST_CHECK;
                end else if (r_lo < SIZE_B) begin
                    n_state = ST_LEAF;
                end else begin
                    n_state = ST_RESULT;
                end
            end

            // read the node unless it lies past the right bound
            ST_CHECK: begin
                if (r_lo >= r_rbc) begin
                    n_state = ST_RESULT;
                end else begin
                    rd_addr_a = r_node;
                    n_state   = ST_CHECK_WAIT;
                end
            end

            // node read back: match found, go down, or move on
            ST_CHECK_WAIT: begin
                if (!cmp_res.a_le) begin
                    n_state = ST_CLIMB;
                end else if (r_span == ONE_B) begin
                    n_val   = EMPTY_MARK;
                    n_count = count_inc;
                    n_state = ST_LEAF;
                end else begin
                    rd_addr_a = r_node << 1;
                    n_state   = ST_DESCEND;
                end
            end

            // one level down a cycle towards the leftmost match
            ST_DESCEND: begin
                n_node = child;
                n_lo   = child_lo;
                n_span = half;
                if (child_lo >= r_rbc) begin
                    n_state = ST_RESULT;
                end else if (half == ONE_B) begin
                    n_val   = EMPTY_MARK;
                    n_count = count_inc;
                    n_state = ST_LEAF;
                end else begin
                    rd_addr_a = child << 1;
                end
            end

            // write the leaf and fetch its sibling
            ST_LEAF: begin
                mem_we    = 1'b1;
                mem_waddr = r_node;
                mem_wdata = r_val;
                rd_addr_a = r_node ^ ROOT;
                n_wnode   = r_node;
                n_state   = ST_UP;
            end

            // one level up a cycle: parent gets the smaller of the pair
            ST_UP: begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = cmp_res.mn;
                rd_addr_a = parent ^ ROOT;
                n_val     = cmp_res.mn;
                n_wnode   = parent;
                if (parent == ROOT) begin
                    n_state = (r_act == ACT_SWEEP) ? ST_CLIMB : ST_RESULT;
                end
            end

            // step to the next subtree on the right
            ST_CLIMB: begin
                if (r_node == ROOT) begin
                    n_state = ST_RESULT;
                end else if (r_node[0]) begin
                    n_node = r_node >> 1;
                    n_lo   = r_lo - r_span;
                    n_span = r_span << 1;
                end else begin
                    n_node  = r_node + AW'(1);
                    n_lo    = r_lo + r_span;
                    n_state = ST_CHECK;
                end
            end

            // hold the result word until taken
            ST_RESULT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // no memory write while waiting for a word
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("memory written while idle");

    // a path update never reads the node it writes
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != ST_CLEAR) |-> (mem_waddr != rd_addr_a))
        else $error("read and write of the same node");

    // the subtree span stays a single power of two during a search
    a_span_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK || r_state == ST_CHECK_WAIT || r_state == ST_DESCEND ||
         r_state == ST_CLIMB) |-> $onehot(r_span))
        else $error("span not one-hot");

    // a set always reports zero
    a_set_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_act == ACT_SET) |-> (o_removed_count == '0))
        else $error("set reported a non-zero count");

    // the count starts from zero for each word
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_count == '0))
        else $error("count not cleared on a new word");

endmodule

### hw/rtl/tsmt_mem.sv
// node memory of the minimum tree: one write port, one registered read port
// depends on tsmt_pkg for the value type
module tsmt_mem
    import tsmt_pkg::*;
#(
    parameter int AW = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_val          i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    output t_val          o_rdata_a
);

    localparam int DEPTH = 1 << AW;

    t_val r_mem [DEPTH];
    t_val r_rdata_a;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
    end

    assign o_rdata_a = r_rdata_a;

endmodule

### hw/rtl/tsmt_cmp.sv
// shared compare unit: node value against the threshold, and the minimum for a path update
// depends on tsmt_pkg for the value and result types
module tsmt_cmp
    import tsmt_pkg::*;
(
    input  t_val     i_node,
    input  t_val     i_thr,
    input  t_val     i_val,
    output t_cmp_res o_res
);

    // threshold test on the node word
    assign o_res.a_le = (i_node <= i_thr);

    // minimum of the carried value and the sibling word
    assign o_res.mn = (i_node < i_val) ? i_node : i_val;

endmodule

### verif/threshold_sweep_min_tree_tb.sv
// self-checking testbench for threshold_sweep_min_tree: slot shadow predictor, random handshakes
// depends on tsmt_pkg and threshold_sweep_min_tree
`timescale 1ns / 100ps

module threshold_sweep_min_tree_tb
    import tsmt_pkg::*;
();

    localparam int SLOTS = 1024;

    // largest value below the empty mark
    localparam t_val MAX_VAL = EMPTY_MARK - t_val'(1);

    // one input word as the sender holds it
    typedef struct packed {
        logic             action;
        logic [POS_W-1:0] pos;
        logic [RB_W-1:0]  rb;
        t_val             val;
    } t_word;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_ready;
    logic             i_action;
    logic [POS_W-1:0] i_position;
    logic [RB_W-1:0]  i_right_bound;
    logic [VAL_W-1:0] i_value;
    logic             o_out_valid;
    logic             i_out_ready   = 1'b0;
    logic [CNT_W-1:0] o_removed_count;

    t_word            drv_word      = '0;
    logic             rst_done      = 1'b0;
    logic             in_taken      = 1'b0;

    t_word            words_to_send[$];
    logic [CNT_W-1:0] pending_counts[$];
    t_val             slot_shadow[SLOTS];

    int               err_count     = 0;
    int               results_seen  = 0;
    int               hold_left     = 0;
    int               holds_done    = 0;
    int               send_gap      = 0;
    int               send_burst    = 0;
    int               recv_gap      = 0;
    int               recv_burst    = 0;

    assign i_action      = drv_word.action;
    assign i_position    = drv_word.pos;
    assign i_right_bound = drv_word.rb;
    assign i_value       = drv_word.val;

    threshold_sweep_min_tree #(
        .SIZE(SLOTS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_position     (i_position),
        .i_right_bound  (i_right_bound),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_removed_count(o_removed_count)
    );

    always #5 i_clk = ~i_clk;

    // apply one word to the slot shadow and return the number of slots it empties
    function automatic logic [CNT_W-1:0] count_removed(t_word w);
        int unsigned      lim;
        t_val             thr;
        logic [CNT_W-1:0] n;
        n = '0;
        if (w.action == ACT_SET) begin
            if (w.pos < SLOTS) slot_shadow[w.pos] = w.val;
        end else begin
            // the empty mark as threshold never matches an empty slot
            thr = (w.val == EMPTY_MARK) ? MAX_VAL : w.val;
            lim = (w.rb > SLOTS) ? SLOTS : w.rb;
            for (int unsigned s = w.pos; s < lim; s++) begin
                if (slot_shadow[POS_W'(s)] <= thr) begin
                    slot_shadow[POS_W'(s)] = EMPTY_MARK;
                    if (n != COUNT_MAX) n++;
                end
            end
        end
        return n;
    endfunction

    // idle length: mostly none or short, a few long, with bursts of no idling
    function automatic int idle_len(ref int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // slot value or threshold, weighted towards the extremes and small numbers
    function automatic t_val pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return MAX_VAL;
            2: return EMPTY_MARK;
            3, 4, 5, 6: return t_val'($urandom_range(0, 1000));
            default: return t_val'($urandom);
        endcase
    endfunction

    task automatic add_word(logic act, int unsigned pos, int unsigned rb, t_val val);
        t_word w;
        w.action = act;
        w.pos    = POS_W'(pos);
        w.rb     = RB_W'(rb);
        w.val    = val;
        words_to_send.push_back(w);
    endtask

    task automatic flag_error(string msg);
        err_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // sender: next word after acceptance, or after its idle gap
    always @(negedge i_clk) begin
        if (rst_done && (!i_in_valid || in_taken)) begin
            if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                drv_word   <= words_to_send.pop_front();
                i_in_valid <= 1'b1;
                send_gap   = idle_len(send_burst);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, and nothing taken while a long hold-off runs
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap = idle_len(recv_burst);
        end
    end

    // long hold-offs of the receiver so that the block backs up into its input
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && results_seen == (holds_done == 0 ? 40 : 500)) begin
            hold_left  <= 400;
            holds_done <= holds_done + 1;
        end
    end

    // predict on each accepted input word, compare each accepted result word
    always @(posedge i_clk) begin
        logic [CNT_W-1:0] want;
        if (rst_done) begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) pending_counts.push_back(count_removed(drv_word));
            if (o_out_valid && i_out_ready) begin
                results_seen <= results_seen + 1;
                if (pending_counts.size() == 0) begin
                    flag_error($sformatf("result word with none expected, removed_count=%0d",
                                         o_removed_count));
                end else begin
                    want = pending_counts.pop_front();
                    if (o_removed_count !== want)
                        flag_error($sformatf("removed_count %0d, expected %0d",
                                             o_removed_count, want));
                end
            end
        end
    end

    // overall time limit
    initial begin
        #15_000_000;
        $display("threshold_sweep_min_tree_tb NOT OK");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        int          win;
        int          r;
        int unsigned p;
        for (int i = 0; i < SLOTS; i++) slot_shadow[POS_W'(i)] = EMPTY_MARK;

        // directed: empty table, extremes, empty mark as value and threshold, bounds
        add_word(ACT_SWEEP, 0, SLOTS, EMPTY_MARK);
        add_word(ACT_SET, 0, 0, '0);
        add_word(ACT_SET, 1023, 0, MAX_VAL);
        add_word(ACT_SET, 5, 2047, EMPTY_MARK);
        add_word(ACT_SET, 6, 0, 100);
        add_word(ACT_SWEEP, 0, SLOTS, EMPTY_MARK);
        add_word(ACT_SET, 1023, 0, '0);
        add_word(ACT_SET, 512, 0, MAX_VAL);
        add_word(ACT_SWEEP, 1023, 2047, '0);
        add_word(ACT_SWEEP, 600, 100, MAX_VAL);
        add_word(ACT_SWEEP, 512, 512, MAX_VAL);
        add_word(ACT_SWEEP, 0, 0, '0);
        add_word(ACT_SET, 700, 0, 50);
        add_word(ACT_SET, 700, 0, 40);
        add_word(ACT_SWEEP, 700, 701, 39);
        add_word(ACT_SWEEP, 700, 701, 40);
        add_word(ACT_SET, 3, 0, 7);
        add_word(ACT_SET, 3, 0, EMPTY_MARK);
        add_word(ACT_SWEEP, 0, SLOTS, MAX_VAL);
        add_word(ACT_SWEEP, 1023, SLOTS, EMPTY_MARK);

        // fill many slots, then one wide sweep for a large count
        for (int i = 0; i < 300; i++)
            add_word(ACT_SET, i * 3 + $urandom_range(0, 2), $urandom_range(0, 2047),
                     t_val'($urandom_range(0, 1 << 20)));
        add_word(ACT_SWEEP, 0, 2047, EMPTY_MARK);

        // random mix around a moving hot window so sweeps find filled slots
        win = $urandom_range(0, SLOTS - 64);
        for (int i = 0; i < 630; i++) begin
            if (i % 64 == 0) win = $urandom_range(0, SLOTS - 64);
            r = $urandom_range(0, 99);
            p = ($urandom_range(0, 1) == 0) ? win + $urandom_range(0, 63)
                                            : $urandom_range(0, SLOTS - 1);
            if (r < 55) begin
                add_word(ACT_SET, p, $urandom_range(0, 2047), pick_value());
            end else if (r < 95) begin
                if ($urandom_range(0, 4) == 0)
                    add_word(ACT_SWEEP, p, $urandom_range(0, 2047), pick_value());
                else
                    add_word(ACT_SWEEP, p, p + $urandom_range(0, 80), pick_value());
            end else begin
                add_word(ACT_SET, p, $urandom_range(0, 2047), EMPTY_MARK);
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;

        // drain: all words sent, all results back, then a quiet spell
        while (words_to_send.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (err_count == 0)
            $display("threshold_sweep_min_tree_tb OK");
        else
            $display("threshold_sweep_min_tree_tb NOT OK");
        $finish;
    end

endmodule

### threshold_sweep_min_tree.f
hw/rtl/tsmt_pkg.sv
hw/rtl/tsmt_mem.sv
hw/rtl/tsmt_cmp.sv
hw/rtl/threshold_sweep_min_tree.sv
verif/threshold_sweep_min_tree_tb.sv
